// File: hw/rtl/led_chase_tail_generator_assert.svh
// ---------------------------------------------------------------------------
// LED chase assertion macros
// Shared assertion shorthands, clocked on clk and disabled during rst_n low.
// ---------------------------------------------------------------------------
`ifndef LED_CHASE_TAIL_GENERATOR_ASSERT_SVH
`define LED_CHASE_TAIL_GENERATOR_ASSERT_SVH

// same-cycle implication
`define LCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lct_pkg.sv
// ---------------------------------------------------------------------------
// LED chase package
// Strip geometry, field widths and register codes.
// ---------------------------------------------------------------------------
package lct_pkg;

    localparam int PIXEL_COUNT = 64;

    localparam int COLOR_W = 8;
    localparam int TAIL_W  = 5;
    // slot runs up to PIXEL_COUNT, head position up to PIXEL_COUNT+1
    localparam int POS_W   = $clog2(PIXEL_COUNT + 2);
    // frame counter runs up to PIXEL_COUNT + tail
    localparam int FRAME_W = $clog2(PIXEL_COUNT + 32);
    // fade product color*(i+1), i+1 at most 31
    localparam int PROD_W  = COLOR_W + TAIL_W;
    // divisor tail+1, at most 32
    localparam int DIV_W   = TAIL_W + 1;
    localparam int CNT_W   = $clog2(PROD_W);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [TAIL_W-1:0] TAIL_RESET = TAIL_W'(6);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COLOR_RED   = 2'd0,
        REG_COLOR_GREEN = 2'd1,
        REG_COLOR_BLUE  = 2'd2,
        REG_TAIL_LENGTH = 2'd3
    } cfg_reg_t;

endpackage

// File: hw/rtl/lct_tick_if.sv
// ---------------------------------------------------------------------------
// LED chase tick channel
// One request per pixel; restart begins a new run.
// ---------------------------------------------------------------------------
interface lct_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// File: hw/rtl/lct_pixel_if.sv
// ---------------------------------------------------------------------------
// LED chase pixel channel
// One RGB pixel with frame and sequence strobes per transfer.
// ---------------------------------------------------------------------------
interface lct_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [lct_pkg::COLOR_W-1:0] pixel_red;
    logic [lct_pkg::COLOR_W-1:0] pixel_green;
    logic [lct_pkg::COLOR_W-1:0] pixel_blue;
    logic                        frame_end;
    logic                        sequence_end;
    logic                        active;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    output frame_end, output sequence_end, output active, input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    input frame_end, input sequence_end, input active, output ready);
endinterface

// File: hw/rtl/led_chase_tail_generator.sv
// ---------------------------------------------------------------------------
// LED chase tail generator
// Pixel stream for a strip chase animation: a head of full color walking
// along the strip with a linearly fading tail behind it.
// ---------------------------------------------------------------------------
// Each tick transfer yields exactly one pixel transfer. A frame is
// PIXEL_COUNT+1 pixels, the last one flagged frame_end; a run is
// PIXEL_COUNT+tail frames, the very last pixel also flagged sequence_end.
// Head color and tail length are sampled from the registers on a restart
// tick; writes during a run apply at the next restart. Outside a run the
// block returns black pixels with active low. Path: a black or head pixel
// goes from the tick transfer straight to the load into the pixel register;
// a tail pixel passes the tick, a multiply state, a bit-serial restoring
// divider producing color*(i+1)/(tail+1), and a load state. The divider,
// one quotient bit per cycle on three channels in parallel, sets the rate.
// The tick side is ready again as soon as the pixel is handed to the output
// register, so a pixel may wait there while the next one is computed.
// ---------------------------------------------------------------------------
module led_chase_tail_generator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [lct_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0] wr_data,
    lct_tick_if.sink                       tick,
    lct_pixel_if.source                    pixel
);

    `include "led_chase_tail_generator_assert.svh"

    localparam int POS_W   = lct_pkg::POS_W;
    localparam int FRAME_W = lct_pkg::FRAME_W;
    localparam int TAIL_W  = lct_pkg::TAIL_W;
    localparam int COLOR_W = lct_pkg::COLOR_W;
    localparam int PROD_W  = lct_pkg::PROD_W;
    localparam int DIV_W   = lct_pkg::DIV_W;
    localparam int CNT_W   = lct_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_PUSH
    } state_t;

    // what the current slot shows
    typedef enum logic [1:0] {
        PK_BLACK,
        PK_HEAD,
        PK_TAIL
    } pix_kind_t;

    // one restoring-division step: {remainder, dividend/quotient shifter}
    function automatic logic [DIV_W+PROD_W-1:0] div_step(
        input logic [DIV_W-1:0]  rem,
        input logic [PROD_W-1:0] dq,
        input logic [DIV_W-1:0]  dvs
    );
        logic [DIV_W:0]   trial;
        logic [DIV_W-1:0] rem_n;
        logic             qbit;
        trial = {rem, dq[PROD_W-1]} - {1'b0, dvs};
        qbit  = ~trial[DIV_W];
        rem_n = qbit ? trial[DIV_W-1:0] : {rem[DIV_W-2:0], dq[PROD_W-1]};
        return {rem_n, dq[PROD_W-2:0], qbit};
    endfunction

    // configuration registers
    logic [COLOR_W-1:0] color_red_reg, color_green_reg, color_blue_reg;
    logic [TAIL_W-1:0]  tail_length_reg;

    // animation state
    state_t             state_reg,       state_next;
    logic               running_reg,     running_next;
    logic [FRAME_W-1:0] frame_reg,       frame_next;
    logic [POS_W-1:0]   head_reg,        head_next;
    logic [TAIL_W-1:0]  tail_now_reg,    tail_now_next;
    logic [POS_W-1:0]   slot_reg,        slot_next;
    logic [COLOR_W-1:0] lat_red_reg,     lat_red_next;
    logic [COLOR_W-1:0] lat_green_reg,   lat_green_next;
    logic [COLOR_W-1:0] lat_blue_reg,    lat_blue_next;
    logic [TAIL_W-1:0]  lat_tail_reg,    lat_tail_next;

    // pixel in progress
    pix_kind_t          kind_reg,        kind_next;
    logic [TAIL_W-1:0]  idx_reg,         idx_next;
    logic               fend_reg,        fend_next;
    logic               send_reg,        send_next;
    logic               act_reg,         act_next;
    logic [DIV_W-1:0]   rem_red_reg,     rem_red_next;
    logic [DIV_W-1:0]   rem_green_reg,   rem_green_next;
    logic [DIV_W-1:0]   rem_blue_reg,    rem_blue_next;
    logic [PROD_W-1:0]  dq_red_reg,      dq_red_next;
    logic [PROD_W-1:0]  dq_green_reg,    dq_green_next;
    logic [PROD_W-1:0]  dq_blue_reg,     dq_blue_next;
    logic [CNT_W-1:0]   cnt_reg,         cnt_next;

    // output register
    logic               out_valid_reg,   out_valid_next;
    logic [COLOR_W-1:0] out_red_reg,     out_red_next;
    logic [COLOR_W-1:0] out_green_reg,   out_green_next;
    logic [COLOR_W-1:0] out_blue_reg,    out_blue_next;
    logic               out_fend_reg,    out_fend_next;
    logic               out_send_reg,    out_send_next;
    logic               out_act_reg,     out_act_next;

    // tick-cycle decode
    logic               tick_xfer;
    logic               eff_run;
    logic [POS_W-1:0]   eff_slot, eff_head, tail_clamp, tail_lo;
    logic [TAIL_W-1:0]  eff_tail, eff_lt;
    logic [FRAME_W-1:0] eff_frame;
    logic               is_tail, is_head, is_fend, is_send;
    logic [FRAME_W:0]   frame_inc, frame_limit;
    logic [DIV_W-1:0]   divisor;
    logic [DIV_W+PROD_W-1:0] step_red, step_green, step_blue;

    assign tick.ready  = (state_reg == ST_IDLE);
    assign tick_xfer   = tick.valid & tick.ready;

    assign pixel.valid        = out_valid_reg;
    assign pixel.pixel_red    = out_red_reg;
    assign pixel.pixel_green  = out_green_reg;
    assign pixel.pixel_blue   = out_blue_reg;
    assign pixel.frame_end    = out_fend_reg;
    assign pixel.sequence_end = out_send_reg;
    assign pixel.active       = out_act_reg;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_red_reg   <= '0;
            color_green_reg <= '0;
            color_blue_reg  <= '0;
            tail_length_reg <= lct_pkg::TAIL_RESET;
        end
        else if (wr_en)
        begin
            case (lct_pkg::cfg_reg_t'(wr_index))
                lct_pkg::REG_COLOR_RED:   color_red_reg   <= wr_data;
                lct_pkg::REG_COLOR_GREEN: color_green_reg <= wr_data;
                lct_pkg::REG_COLOR_BLUE:  color_blue_reg  <= wr_data;
                lct_pkg::REG_TAIL_LENGTH: tail_length_reg <= wr_data[TAIL_W-1:0];
                default:                  ;
            endcase
        end
    end

    // A restart tick acts as if the counters were already back at zero.
    always_comb
    begin
        eff_run   = tick.restart | running_reg;
        eff_slot  = tick.restart ? '0 : slot_reg;
        eff_head  = tick.restart ? '0 : head_reg;
        eff_tail  = tick.restart ? '0 : tail_now_reg;
        eff_frame = tick.restart ? '0 : frame_reg;
        eff_lt    = tick.restart ? tail_length_reg : lat_tail_reg;

        // tail never reaches back past slot zero
        tail_clamp = (POS_W'(eff_tail) > eff_head) ? eff_head : POS_W'(eff_tail);
        tail_lo    = eff_head - tail_clamp;
        is_tail    = (eff_slot >= tail_lo) && (eff_slot < eff_head);
        is_head    = (eff_slot == eff_head);

        is_fend     = (eff_slot >= POS_W'(lct_pkg::PIXEL_COUNT));
        frame_inc   = {1'b0, eff_frame} + (FRAME_W+1)'(1);
        frame_limit = (FRAME_W+1)'(lct_pkg::PIXEL_COUNT) + (FRAME_W+1)'(eff_lt);
        is_send     = is_fend && (frame_inc >= frame_limit);
    end

    assign divisor    = DIV_W'(lat_tail_reg) + DIV_W'(1);
    assign step_red   = div_step(rem_red_reg,   dq_red_reg,   divisor);
    assign step_green = div_step(rem_green_reg, dq_green_reg, divisor);
    assign step_blue  = div_step(rem_blue_reg,  dq_blue_reg,  divisor);

    always_comb
    begin
        state_next     = state_reg;
        running_next   = running_reg;
        frame_next     = frame_reg;
        head_next      = head_reg;
        tail_now_next  = tail_now_reg;
        slot_next      = slot_reg;
        lat_red_next   = lat_red_reg;
        lat_green_next = lat_green_reg;
        lat_blue_next  = lat_blue_reg;
        lat_tail_next  = lat_tail_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        fend_next      = fend_reg;
        send_next      = send_reg;
        act_next       = act_reg;
        rem_red_next   = rem_red_reg;
        rem_green_next = rem_green_reg;
        rem_blue_next  = rem_blue_reg;
        dq_red_next    = dq_red_reg;
        dq_green_next  = dq_green_reg;
        dq_blue_next   = dq_blue_reg;
        cnt_next       = cnt_reg;

        // pixel leaves the output register
        out_valid_next = out_valid_reg & ~pixel.ready;
        out_red_next   = out_red_reg;
        out_green_next = out_green_reg;
        out_blue_next  = out_blue_reg;
        out_fend_next  = out_fend_reg;
        out_send_next  = out_send_reg;
        out_act_next   = out_act_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (tick_xfer)
                begin
                    if (tick.restart)
                    begin
                        lat_red_next   = color_red_reg;
                        lat_green_next = color_green_reg;
                        lat_blue_next  = color_blue_reg;
                        lat_tail_next  = tail_length_reg;
                    end
                    idx_next   = TAIL_W'(eff_slot - tail_lo);
                    act_next   = eff_run;
                    fend_next  = eff_run & is_fend;
                    send_next  = eff_run & is_send;
                    kind_next  = PK_BLACK;
                    state_next = ST_PUSH;
                    if (eff_run)
                    begin
                        running_next = 1'b1;
                        if (is_tail)
                        begin
                            kind_next  = PK_TAIL;
                            state_next = ST_MUL;
                        end
                        else if (is_head)
                        begin
                            kind_next = PK_HEAD;
                        end

                        if (is_fend)
                        begin
                            slot_next  = '0;
                            frame_next = frame_inc[FRAME_W-1:0];
                            if (is_send)
                            begin
                                running_next = 1'b0;
                            end
                            // head phase moves on; fade phase shrinks the tail
                            if (eff_head < POS_W'(lct_pkg::PIXEL_COUNT + 1))
                            begin
                                head_next     = eff_head + POS_W'(1);
                                tail_now_next = (eff_tail < eff_lt) ? eff_tail + TAIL_W'(1)
                                                                     : eff_tail;
                            end
                            else
                            begin
                                head_next     = eff_head;
                                tail_now_next = (eff_tail != '0) ? eff_tail - TAIL_W'(1)
                                                                 : eff_tail;
                            end
                        end
                        else
                        begin
                            slot_next     = eff_slot + POS_W'(1);
                            head_next     = eff_head;
                            tail_now_next = eff_tail;
                            frame_next    = eff_frame;
                        end
                    end
                end
            end

            ST_MUL:
            begin
                dq_red_next    = PROD_W'(lat_red_reg)   * (PROD_W'(idx_reg) + PROD_W'(1));
                dq_green_next  = PROD_W'(lat_green_reg) * (PROD_W'(idx_reg) + PROD_W'(1));
                dq_blue_next   = PROD_W'(lat_blue_reg)  * (PROD_W'(idx_reg) + PROD_W'(1));
                rem_red_next   = '0;
                rem_green_next = '0;
                rem_blue_next  = '0;
                cnt_next       = '0;
                state_next     = ST_DIV;
            end

            ST_DIV:
            begin
                {rem_red_next,   dq_red_next}   = step_red;
                {rem_green_next, dq_green_next} = step_green;
                {rem_blue_next,  dq_blue_next}  = step_blue;
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PROD_W - 1))
                begin
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (!out_valid_reg || pixel.ready)
                begin
                    out_valid_next = 1'b1;
                    case (kind_reg)
                        PK_HEAD:
                        begin
                            out_red_next   = lat_red_reg;
                            out_green_next = lat_green_reg;
                            out_blue_next  = lat_blue_reg;
                        end
                        PK_TAIL:
                        begin
                            out_red_next   = dq_red_reg[COLOR_W-1:0];
                            out_green_next = dq_green_reg[COLOR_W-1:0];
                            out_blue_next  = dq_blue_reg[COLOR_W-1:0];
                        end
                        default:
                        begin
                            out_red_next   = '0;
                            out_green_next = '0;
                            out_blue_next  = '0;
                        end
                    endcase
                    out_fend_next = fend_reg;
                    out_send_next = send_reg;
                    out_act_next  = act_reg;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= 1'b0;
            frame_reg     <= '0;
            head_reg      <= '0;
            tail_now_reg  <= '0;
            slot_reg      <= '0;
            lat_red_reg   <= '0;
            lat_green_reg <= '0;
            lat_blue_reg  <= '0;
            lat_tail_reg  <= '0;
            kind_reg      <= PK_BLACK;
            idx_reg       <= '0;
            fend_reg      <= 1'b0;
            send_reg      <= 1'b0;
            act_reg       <= 1'b0;
            rem_red_reg   <= '0;
            rem_green_reg <= '0;
            rem_blue_reg  <= '0;
            dq_red_reg    <= '0;
            dq_green_reg  <= '0;
            dq_blue_reg   <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_red_reg   <= '0;
            out_green_reg <= '0;
            out_blue_reg  <= '0;
            out_fend_reg  <= 1'b0;
            out_send_reg  <= 1'b0;
            out_act_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            running_reg   <= running_next;
            frame_reg     <= frame_next;
            head_reg      <= head_next;
            tail_now_reg  <= tail_now_next;
            slot_reg      <= slot_next;
            lat_red_reg   <= lat_red_next;
            lat_green_reg <= lat_green_next;
            lat_blue_reg  <= lat_blue_next;
            lat_tail_reg  <= lat_tail_next;
            kind_reg      <= kind_next;
            idx_reg       <= idx_next;
            fend_reg      <= fend_next;
            send_reg      <= send_next;
            act_reg       <= act_next;
            rem_red_reg   <= rem_red_next;
            rem_green_reg <= rem_green_next;
            rem_blue_reg  <= rem_blue_next;
            dq_red_reg    <= dq_red_next;
            dq_green_reg  <= dq_green_next;
            dq_blue_reg   <= dq_blue_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_red_reg   <= out_red_next;
            out_green_reg <= out_green_next;
            out_blue_reg  <= out_blue_next;
            out_fend_reg  <= out_fend_next;
            out_send_reg  <= out_send_next;
            out_act_reg   <= out_act_next;
        end
    end

    // fade quotient never exceeds the head color, so it fits one channel
    `LCT_ASSERT_IMP(a_quot_fits, (state_reg == ST_PUSH) && (kind_reg == PK_TAIL), (dq_red_reg[PROD_W-1:COLOR_W] == '0) && (dq_green_reg[PROD_W-1:COLOR_W] == '0) && (dq_blue_reg[PROD_W-1:COLOR_W] == '0), "fade quotient overflow")
    `LCT_ASSERT_IMP(a_tail_bound, running_reg, tail_now_reg <= lat_tail_reg, "tail beyond latched length")
    `LCT_ASSERT_IMP(a_slot_bound, 1'b1, slot_reg <= POS_W'(lct_pkg::PIXEL_COUNT), "slot past frame end")
    `LCT_ASSERT_NXT(a_busy_after_tick, tick_xfer, state_reg != ST_IDLE, "tick transfer not taken up")
    `LCT_ASSERT_IMP(a_send_in_fend, out_valid_reg && out_send_reg, out_fend_reg && out_act_reg, "sequence end off a frame end")

endmodule

// File: tb/led_chase_tail_generator_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LED chase tail generator testbench
// Drives tick transfers and register writes into the chase generator and
// checks every pixel transfer against an in-bench model of the animation:
// head/tail geometry, fade arithmetic, frame and sequence strobes, idle black.
// ---------------------------------------------------------------------------
module led_chase_tail_generator_tb;

    localparam int PIXEL_COUNT = lct_pkg::PIXEL_COUNT;
    localparam int COLOR_W     = lct_pkg::COLOR_W;
    localparam int TAIL_W      = lct_pkg::TAIL_W;
    localparam int POS_W       = lct_pkg::POS_W;
    localparam int FRAME_W     = lct_pkg::FRAME_W;
    localparam int CFG_IDX_W   = lct_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = lct_pkg::CFG_DATA_W;

    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    // room for a tail pixel's multiply and divide; margin before touching registers
    localparam int SETTLE_CYCLES = 24;
    // short-run tick budget spread over the three idling phases
    localparam int RANDOM_ITEMS  = 1584;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               frame_end;
        logic               sequence_end;
        logic               active;
    } pixel_t;

    // -----------------------------------------------------------------------
    // Scoreboard: register mirror, animation model and queue of pixels owed
    // -----------------------------------------------------------------------
    class chase_scoreboard;
        // register mirror, as written through the config port
        logic [COLOR_W-1:0] reg_red;
        logic [COLOR_W-1:0] reg_green;
        logic [COLOR_W-1:0] reg_blue;
        logic [TAIL_W-1:0]  reg_tail;
        // animation state; colors and tail are captured on a restart tick
        logic [FRAME_W-1:0] frame_no;
        logic [POS_W-1:0]   head_pos;
        logic [POS_W-1:0]   slot;
        logic [TAIL_W-1:0]  tail_cur;
        logic [TAIL_W-1:0]  run_tail;
        logic [COLOR_W-1:0] run_red;
        logic [COLOR_W-1:0] run_green;
        logic [COLOR_W-1:0] run_blue;
        logic               running;
        pixel_t             pending_pixels[$];
        int                 errors;

        function new();
            reg_red   = '0;
            reg_green = '0;
            reg_blue  = '0;
            reg_tail  = lct_pkg::TAIL_RESET;
            frame_no  = '0;
            head_pos  = '0;
            slot      = '0;
            tail_cur  = '0;
            run_tail  = '0;
            run_red   = '0;
            run_green = '0;
            run_blue  = '0;
            running   = 1'b0;
            errors    = 0;
        endfunction

        function void write_reg(lct_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                lct_pkg::REG_COLOR_RED:   reg_red   = value[COLOR_W-1:0];
                lct_pkg::REG_COLOR_GREEN: reg_green = value[COLOR_W-1:0];
                lct_pkg::REG_COLOR_BLUE:  reg_blue  = value[COLOR_W-1:0];
                lct_pkg::REG_TAIL_LENGTH: reg_tail  = value[TAIL_W-1:0];
                default: ;
            endcase
        endfunction

        // tail step k of n: color*(k+1)/(n+1), rounded down
        function logic [COLOR_W-1:0] faded(logic [COLOR_W-1:0] c, int step);
            return COLOR_W'((int'(c) * (step + 1)) / (int'(run_tail) + 1));
        endfunction

        // pixel produced by one tick, advancing the animation
        function pixel_t chase_pixel(logic restart_bit);
            pixel_t            px;
            logic [TAIL_W-1:0] t;
            int                lo;
            px = '0;
            if (restart_bit) begin
                running   = 1'b1;
                frame_no  = '0;
                head_pos  = '0;
                slot      = '0;
                tail_cur  = '0;
                run_red   = reg_red;
                run_green = reg_green;
                run_blue  = reg_blue;
                run_tail  = reg_tail;
            end
            if (!running)
                return px;

            // tail cannot reach past slot zero
            t = tail_cur;
            if (int'(t) > int'(head_pos))
                t = TAIL_W'(head_pos);
            lo = int'(head_pos) - int'(t);
            if (int'(slot) >= lo && slot < head_pos) begin
                px.red   = faded(run_red,   int'(slot) - lo);
                px.green = faded(run_green, int'(slot) - lo);
                px.blue  = faded(run_blue,  int'(slot) - lo);
            end else if (slot == head_pos) begin
                px.red   = run_red;
                px.green = run_green;
                px.blue  = run_blue;
            end
            px.active    = 1'b1;
            px.frame_end = (int'(slot) >= PIXEL_COUNT);

            if (px.frame_end) begin
                slot = '0;
                if (int'(frame_no) + 1 >= PIXEL_COUNT + int'(run_tail)) begin
                    px.sequence_end = 1'b1;
                    running         = 1'b0;
                end
                frame_no = frame_no + 1'b1;
                // head walks off the strip, then the tail drains away
                if (int'(head_pos) < PIXEL_COUNT + 1) begin
                    head_pos = head_pos + 1'b1;
                    if (tail_cur < run_tail)
                        tail_cur = tail_cur + 1'b1;
                end else if (tail_cur != '0) begin
                    tail_cur = tail_cur - 1'b1;
                end
            end else begin
                slot = slot + 1'b1;
            end
            return px;
        endfunction

        function void note_tick(logic restart_bit);
            pending_pixels.push_back(chase_pixel(restart_bit));
        endfunction

        function void mismatch(string field, int want, int got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected pixel, expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_pixels.pop_front();
            if (want.red !== got.red)
                mismatch("pixel_red", want.red, got.red);
            if (want.green !== got.green)
                mismatch("pixel_green", want.green, got.green);
            if (want.blue !== got.blue)
                mismatch("pixel_blue", want.blue, got.blue);
            if (want.frame_end !== got.frame_end)
                mismatch("frame_end", want.frame_end, got.frame_end);
            if (want.sequence_end !== got.sequence_end)
                mismatch("sequence_end", want.sequence_end, got.sequence_end);
            if (want.active !== got.active)
                mismatch("active", want.active, got.active);
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT hookup
    // -----------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    lct_tick_if  tick_ch();
    lct_pixel_if pixel_ch();

    chase_scoreboard sb;
    int              send_idle_pct;
    int              recv_idle_pct;
    int              idle_cycles = 0;

    led_chase_tail_generator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .tick     (tick_ch),
        .pixel    (pixel_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Monitors. Everything is sampled at the edge before the NBA updates, so
    // the driver and the DUT registers cannot race the checks.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pixel_t got;
        if (rst_n && tick_ch.valid && tick_ch.ready)
            sb.note_tick(tick_ch.restart);
        if (rst_n && pixel_ch.valid && pixel_ch.ready) begin
            got = {pixel_ch.pixel_red, pixel_ch.pixel_green, pixel_ch.pixel_blue,
                   pixel_ch.frame_end, pixel_ch.sequence_end, pixel_ch.active};
            sb.check_pixel(got);
        end
    end

    // output backpressure, rate set by the current phase
    always @(posedge clk)
    begin
        if (rst_n)
            pixel_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // hang detector: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) ||
            (pixel_ch.valid && pixel_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d pixels outstanding",
                     $time, STALL_LIMIT, sb.pending_pixels.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // -----------------------------------------------------------------------
    // Driver tasks. All are entered right after a rising edge.
    // -----------------------------------------------------------------------

    // one tick transfer, with a random gap in front of it; valid stays high
    // afterwards so back-to-back ticks need no second assignment
    task automatic send_tick(input logic restart_bit);
        if ($urandom_range(99) < send_idle_pct) begin
            tick_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.restart <= restart_bit;
        do @(posedge clk); while (!tick_ch.ready);
    endtask

    // stop ticking, collect every owed pixel, then let the datapath settle
    task automatic pause_ticks();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves wr_en high; load_setup drops it after the last write
    task automatic write_reg(input lct_pkg::cfg_reg_t idx,
                             input logic [CFG_DATA_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic load_setup(input logic [COLOR_W-1:0] red,
                              input logic [COLOR_W-1:0] green,
                              input logic [COLOR_W-1:0] blue,
                              input logic [TAIL_W-1:0]  tail);
        write_reg(lct_pkg::REG_COLOR_RED,   red);
        write_reg(lct_pkg::REG_COLOR_GREEN, green);
        write_reg(lct_pkg::REG_COLOR_BLUE,  blue);
        write_reg(lct_pkg::REG_TAIL_LENGTH, CFG_DATA_W'(tail));
        wr_en <= 1'b0;
    endtask

    // extremes show up often
    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return COLOR_W'($urandom);
        endcase
    endfunction

    function automatic logic [TAIL_W-1:0] pick_tail();
        case ($urandom_range(4))
            0:       return '0;
            1:       return '1;
            default: return TAIL_W'($urandom_range(31));
        endcase
    endfunction

    // One idling phase: short runs with random setups. Some short runs skip
    // the opening restart and so continue the previous run after a register
    // write, which must not affect it. Rare restarts inside a run abandon it
    // mid-frame.
    task automatic run_phase(input int s_pct, input int r_pct);
        int budget;
        int length;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;

        budget = RANDOM_ITEMS / 3;
        while (budget > 0) begin
            pause_ticks();
            load_setup(pick_color(), pick_color(), pick_color(), pick_tail());
            length = $urandom_range(40, 400);
            if (length > budget)
                length = budget;
            send_tick($urandom_range(3) != 0);
            repeat (length - 1)
                send_tick($urandom_range(99) == 0);
            budget -= length;
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        sb             = new();
        rst_n          = 1'b0;
        wr_en          = 1'b0;
        wr_index       = lct_pkg::REG_COLOR_RED;
        wr_data        = '0;
        tick_ch.valid   = 1'b0;
        tick_ch.restart = 1'b0;
        pixel_ch.ready  = 1'b0;
        send_idle_pct  = 35;
        recv_idle_pct  = 62;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // idle before any restart: black, active low
        send_tick(1'b0);
        send_tick(1'b0);
        // run on reset registers: black head, tail length 6
        send_tick(1'b1);
        send_tick(1'b0);

        // full-scale, zero and mixed colors, longest tail
        pause_ticks();
        load_setup('1, '0, 8'hAA, '1);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // register writes mid-run only apply at the next restart
        pause_ticks();
        load_setup(8'h55, '1, 8'h0F, '0);
        repeat (3) send_tick(1'b0);

        // back-to-back restarts, then a zero-tail run
        send_tick(1'b1);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);

        // random part, idling: sender/receiver, swapped, then none
        run_phase(35, 62);
        run_phase(62, 35);
        run_phase(0, 0);

        tick_ch.valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge clk);
        // catch any stray pixel after the last one owed
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
